@@ rtl/mrpt_pkg.sv @@
// ----------------------------------------------------------------------------
// mrpt_pkg
// shared types, command codes and constants of the primality test core
// ----------------------------------------------------------------------------
package mrpt_pkg;

   // default working width of the arithmetic
   localparam int WIDTH_DEFAULT = 32;
   // width of the number and base fields on the ports
   localparam int FIELD_W       = 32;
   // reset value of the small limit register
   localparam logic [FIELD_W-1:0] LIMIT_RESET = 32'd1024;

   // input word
   typedef struct packed {
      logic [FIELD_W-1:0] number;
      logic [FIELD_W-1:0] base;
   } req_type;

   // result word
   typedef struct packed {
      logic prime_flag;
      logic method;
   } rsp_type;

   // commands from controller to datapath
   typedef enum logic [3:0] {
      CMD_NONE        = 4'd0,
      CMD_LOAD        = 4'd1,
      CMD_TRIAL_START = 4'd2,
      CMD_BASE_START  = 4'd3,
      CMD_DIV_STEP    = 4'd4,
      CMD_BASE_WB     = 4'd5,
      CMD_NEXT_DIV    = 4'd6,
      CMD_SPLIT_INIT  = 4'd7,
      CMD_SPLIT_STEP  = 4'd8,
      CMD_MUL_XB      = 4'd9,
      CMD_MUL_BB      = 4'd10,
      CMD_MUL_XX      = 4'd11,
      CMD_MUL_STEP    = 4'd12,
      CMD_X_WB        = 4'd13,
      CMD_B_WB        = 4'd14,
      CMD_XX_WB       = 4'd15
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic mode_trial;
      logic n_lt_2;
      logic n_even;
      logic d_lsb;
      logic d_zero;
      logic div_busy;
      logic trial_stop;
      logic rem_zero;
      logic base_zero;
      logic mul_busy;
      logic x_one;
      logic x_nm1;
      logic s_gt1;
   } status_type;

endpackage

@@ rtl/mrpt_datapath.sv @@
// ----------------------------------------------------------------------------
// mrpt_datapath
// operand registers, bit-serial divider and double-and-add modular multiplier
// ----------------------------------------------------------------------------
module mrpt_datapath #(
   parameter int WIDTH = mrpt_pkg::WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic [mrpt_pkg::FIELD_W-1:0] csr_data,
   input  mrpt_pkg::req_type            req_data,
   input  mrpt_pkg::cmd_type            cmd,
   output mrpt_pkg::status_type         status
);
   import mrpt_pkg::*;

   localparam int CW   = $clog2(WIDTH + 1);
   localparam int CMPW = (WIDTH > FIELD_W) ? WIDTH : FIELD_W;

   logic [WIDTH-1:0]   n_ff, n_in, base_ff, base_in, x_ff, x_in, i_ff, i_in;
   logic [WIDTH-1:0]   d_ff, d_in, rem_ff, rem_in, quo_ff, quo_in, dv_ff, dv_in;
   logic [WIDTH-1:0]   acc_ff, acc_in, ma_ff, ma_in, mb_ff, mb_in;
   logic [CW-1:0]      s_ff, s_in, cnt_ff, cnt_in;
   logic [FIELD_W-1:0] limit_ff, limit_in;

   logic [WIDTH-1:0]   nm1;
   logic [WIDTH:0]     div_t;
   logic               div_ge;
   logic [WIDTH-1:0]   div_rem, acc_step, ma_step;

   // (a + b) mod m with a, b below m
   function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] a,
                                                input logic [WIDTH-1:0] b,
                                                input logic [WIDTH-1:0] m);
      logic [WIDTH-1:0] room;
      room = m - b;
      return (a >= room) ? (a - room) : (a + b);
   endfunction

   assign nm1 = n_ff - WIDTH'(1);

   // one restoring division step
   assign div_t   = {rem_ff, quo_ff[WIDTH-1]};
   assign div_ge  = (div_t >= {1'b0, dv_ff});
   assign div_rem = div_ge ? WIDTH'(div_t - {1'b0, dv_ff}) : div_t[WIDTH-1:0];

   // one double-and-add multiplication step
   assign acc_step = mb_ff[0] ? add_mod(acc_ff, ma_ff, n_ff) : acc_ff;
   assign ma_step  = add_mod(ma_ff, ma_ff, n_ff);

   // next-state logic driven by command
   always_comb begin
      n_in     = n_ff;
      base_in  = base_ff;
      x_in     = x_ff;
      i_in     = i_ff;
      d_in     = d_ff;
      s_in     = s_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dv_in    = dv_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      limit_in = csr_write ? csr_data : limit_ff;
      case (cmd)
         CMD_LOAD: begin
            n_in    = WIDTH'(req_data.number);
            base_in = WIDTH'(req_data.base);
            i_in    = WIDTH'(2);
            x_in    = WIDTH'(1);
         end
         CMD_TRIAL_START: begin
            quo_in = n_ff;
            rem_in = '0;
            dv_in  = i_ff;
            cnt_in = CW'(WIDTH);
         end
         CMD_BASE_START: begin
            quo_in = base_ff;
            rem_in = '0;
            dv_in  = n_ff;
            cnt_in = CW'(WIDTH);
         end
         CMD_DIV_STEP: begin
            rem_in = div_rem;
            quo_in = {quo_ff[WIDTH-2:0], div_ge};
            cnt_in = cnt_ff - CW'(1);
         end
         CMD_BASE_WB:  base_in = rem_ff;
         CMD_NEXT_DIV: i_in = i_ff + WIDTH'(1);
         CMD_SPLIT_INIT: begin
            d_in = nm1;
            s_in = '0;
         end
         CMD_SPLIT_STEP: begin
            d_in = d_ff >> 1;
            s_in = s_ff + CW'(1);
         end
         CMD_MUL_XB: begin
            acc_in = '0;
            ma_in  = x_ff;
            mb_in  = base_ff;
         end
         CMD_MUL_BB: begin
            acc_in = '0;
            ma_in  = base_ff;
            mb_in  = base_ff;
         end
         CMD_MUL_XX: begin
            acc_in = '0;
            ma_in  = x_ff;
            mb_in  = x_ff;
         end
         CMD_MUL_STEP: begin
            acc_in = acc_step;
            ma_in  = ma_step;
            mb_in  = mb_ff >> 1;
         end
         CMD_X_WB: x_in = acc_ff;
         CMD_B_WB: begin
            base_in = acc_ff;
            d_in    = d_ff >> 1;
         end
         CMD_XX_WB: begin
            x_in = acc_ff;
            s_in = s_ff - CW'(1);
         end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
      n_ff    <= n_in;
      base_ff <= base_in;
      x_ff    <= x_in;
      i_ff    <= i_in;
      d_ff    <= d_in;
      s_ff    <= s_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dv_ff   <= dv_in;
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
   end

   // status flags
   always_comb begin
      status.mode_trial = (n_ff < WIDTH'(4)) || (CMPW'(n_ff) < CMPW'(limit_ff));
      status.n_lt_2     = (n_ff < WIDTH'(2));
      status.n_even     = ~n_ff[0];
      status.d_lsb      = d_ff[0];
      status.d_zero     = (d_ff == '0);
      status.div_busy   = (cnt_ff != '0);
      status.trial_stop = (i_ff > quo_ff);
      status.rem_zero   = (rem_ff == '0);
      status.base_zero  = (base_ff == '0);
      status.mul_busy   = (mb_ff != '0);
      status.x_one      = (x_ff == WIDTH'(1));
      status.x_nm1      = (x_ff == nm1);
      status.s_gt1      = (s_ff > CW'(1));
   end

endmodule

@@ rtl/mrpt_ctrl.sv @@
// ----------------------------------------------------------------------------
// mrpt_ctrl
// sequencer for trial division and one miller-rabin round, plus result register
// ----------------------------------------------------------------------------
module mrpt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mrpt_pkg::rsp_type    rsp_data,
   input  mrpt_pkg::status_type status,
   output mrpt_pkg::cmd_type    cmd
);
   import mrpt_pkg::*;

   typedef enum logic [14:0] {
      ST_IDLE        = 15'h0001,
      ST_CLASSIFY    = 15'h0002,
      ST_TRIAL_START = 15'h0004,
      ST_TRIAL_RUN   = 15'h0008,
      ST_SPLIT       = 15'h0010,
      ST_BASE_RUN    = 15'h0020,
      ST_BASE_CHECK  = 15'h0040,
      ST_POW_CHECK   = 15'h0080,
      ST_XB_RUN      = 15'h0100,
      ST_BB_START    = 15'h0200,
      ST_BB_RUN      = 15'h0400,
      ST_SQ_CHECK    = 15'h0800,
      ST_XX_RUN      = 15'h1000,
      ST_SQ_TEST     = 15'h2000,
      ST_DONE        = 15'h4000
   } state_type;

   state_type state_ff, state_in;
   rsp_type   res_ff, res_in, rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // state transitions and commands
   always_comb begin
      state_in     = state_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = CMD_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (status.mode_trial) begin
               if (status.n_lt_2) begin
                  res_in   = '{prime_flag: 1'b0, method: 1'b0};
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_TRIAL_START;
               end
            end else if (status.n_even) begin
               res_in   = '{prime_flag: 1'b0, method: 1'b1};
               state_in = ST_DONE;
            end else begin
               cmd      = CMD_SPLIT_INIT;
               state_in = ST_SPLIT;
            end
         end
         ST_TRIAL_START: begin
            cmd      = CMD_TRIAL_START;
            state_in = ST_TRIAL_RUN;
         end
         ST_TRIAL_RUN: begin
            if (status.div_busy) begin
               cmd = CMD_DIV_STEP;
            end else if (status.trial_stop) begin
               res_in   = '{prime_flag: 1'b1, method: 1'b0};
               state_in = ST_DONE;
            end else if (status.rem_zero) begin
               res_in   = '{prime_flag: 1'b0, method: 1'b0};
               state_in = ST_DONE;
            end else begin
               cmd      = CMD_NEXT_DIV;
               state_in = ST_TRIAL_START;
            end
         end
         // strip factors of two from number-1
         ST_SPLIT: begin
            if (!status.d_lsb) begin
               cmd = CMD_SPLIT_STEP;
            end else begin
               cmd      = CMD_BASE_START;
               state_in = ST_BASE_RUN;
            end
         end
         ST_BASE_RUN: begin
            if (status.div_busy) begin
               cmd = CMD_DIV_STEP;
            end else begin
               cmd      = CMD_BASE_WB;
               state_in = ST_BASE_CHECK;
            end
         end
         ST_BASE_CHECK: begin
            if (status.base_zero) begin
               res_in   = '{prime_flag: 1'b1, method: 1'b1};
               state_in = ST_DONE;
            end else begin
               state_in = ST_POW_CHECK;
            end
         end
         // square-and-multiply over the exponent bits
         ST_POW_CHECK: begin
            if (!status.d_zero) begin
               if (status.d_lsb) begin
                  cmd      = CMD_MUL_XB;
                  state_in = ST_XB_RUN;
               end else begin
                  cmd      = CMD_MUL_BB;
                  state_in = ST_BB_RUN;
               end
            end else if (status.x_one || status.x_nm1) begin
               res_in   = '{prime_flag: 1'b1, method: 1'b1};
               state_in = ST_DONE;
            end else begin
               state_in = ST_SQ_CHECK;
            end
         end
         ST_XB_RUN: begin
            if (status.mul_busy) begin
               cmd = CMD_MUL_STEP;
            end else begin
               cmd      = CMD_X_WB;
               state_in = ST_BB_START;
            end
         end
         ST_BB_START: begin
            cmd      = CMD_MUL_BB;
            state_in = ST_BB_RUN;
         end
         ST_BB_RUN: begin
            if (status.mul_busy) begin
               cmd = CMD_MUL_STEP;
            end else begin
               cmd      = CMD_B_WB;
               state_in = ST_POW_CHECK;
            end
         end
         // repeated squaring looking for number-1
         ST_SQ_CHECK: begin
            if (status.s_gt1) begin
               cmd      = CMD_MUL_XX;
               state_in = ST_XX_RUN;
            end else begin
               res_in   = '{prime_flag: 1'b0, method: 1'b1};
               state_in = ST_DONE;
            end
         end
         ST_XX_RUN: begin
            if (status.mul_busy) begin
               cmd = CMD_MUL_STEP;
            end else begin
               cmd      = CMD_XX_WB;
               state_in = ST_SQ_TEST;
            end
         end
         ST_SQ_TEST: begin
            if (status.x_nm1) begin
               res_in   = '{prime_flag: 1'b1, method: 1'b1};
               state_in = ST_DONE;
            end else if (status.x_one) begin
               res_in   = '{prime_flag: 1'b0, method: 1'b1};
               state_in = ST_DONE;
            end else begin
               state_in = ST_SQ_CHECK;
            end
         end
         // hand the word to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

endmodule

@@ rtl/miller_rabin_prime_test_core.sv @@
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_core
// trial division for small numbers, one miller-rabin round per word otherwise
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_data (number, base)
//  rsp      out        rsp_valid/rsp_stall  rsp_data (prime_flag, method)
//  csr      in         csr_write            csr_data (small limit)
//
//  one word at a time; trial division tries up to sqrt(number) divisors,
//  each a bit-serial division
//  a round runs a setup (split of number-1, base reduction), then one or two
//  modular multiplies per exponent bit and one per squaring
//  synchronous reset clears the sequencer and sets the small limit to 1024
//  a new word is taken while a finished result waits on a stalled rsp
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_core #(
   parameter int WIDTH = mrpt_pkg::WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  mrpt_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output mrpt_pkg::rsp_type            rsp_data,
   input  logic                         csr_write,
   input  logic [mrpt_pkg::FIELD_W-1:0] csr_data
);
   import mrpt_pkg::*;

   cmd_type    cmd;
   status_type status;

   // arithmetic and operand storage
   mrpt_datapath #(
      .WIDTH(WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .csr_write(csr_write),
      .csr_data (csr_data),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status)
   );

   // sequencer and result register
   mrpt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .status   (status),
      .cmd      (cmd)
   );

endmodule
